@@ sv/hft_pkg.sv @@
// ----------------------------------------------------------------------------
// hft_pkg: shared types and constants for the sensor reply decoder
// Frame record between the front and back parts, status codes, CRC-8 step.
// ----------------------------------------------------------------------------
package hft_pkg;

    // Reply layout: byte 0 status, bytes 1..5 payload, byte 6 check byte.
    localparam int unsigned LAST_DATA   = 6;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned CODE_W      = 20;
    localparam int unsigned PAYLOAD_W   = 2 * CODE_W;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam int unsigned BUSY_BIT    = 7;
    localparam int unsigned CAL_BIT     = 3;

    // Scaling: humidity = floor(h * 10000 / 2^20),
    // temperature = floor(t * 20000 / 2^20) - 5000.
    localparam int unsigned HUM_W       = 14;
    localparam int unsigned TEMP_W      = 15;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [15:0] TEMP_OFFSET = 16'd5000;
    localparam int unsigned HPROD_W     = CODE_W + HUM_W;
    localparam int unsigned TPROD_W     = CODE_W + TEMP_W;

    // Queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_BUSY  = 2'd2,
        ST_UNCAL = 2'd3
    } frame_status_t;

    typedef struct packed {
        frame_status_t        status;
        logic [CODE_W-1:0]    hum_code;
        logic [CODE_W-1:0]    temp_code;
    } frame_rec_t;

    // One byte of CRC-8, MSB first, no final XOR.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ sv/humidity_temp_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder: seven-byte humidity/temperature reply decoder
// Checks CRC and status of each sensor reply and holds the last good reading.
// ----------------------------------------------------------------------------
// The block takes one reply byte per transfer on the input channel, with
// frame_start marking byte 0 of a new reply; a start in the middle of a reply
// drops the partial one, and after the check byte the next byte begins a new
// reply anyway. Bytes 0 to 5 run through a CRC-8 (polynomial 0x31, seed 0xFF,
// MSB first) and produce no output. The check byte produces exactly one output
// transfer: frame_status is 0 for a good reply, 1 for a CRC mismatch, 2 for a
// busy sensor and 3 for an uncalibrated sensor, in that order of priority.
// humidity_centi and temperature_centi always carry the last good reading
// (0.01 percent and 0.01 degC, the latter two's complement) and are zero
// until the first good reply. A byte is accepted every cycle as long as the
// two-entry frame queue has room; in_ready drops only when four finished
// frames are waiting behind a stalled output: one in the output register,
// one in the constant-multiply stage and two in the queue. A result passes
// from its check byte through the frame queue and the constant-multiply
// stage into the output register, where it sits until it is taken.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        frame_status,
    output logic [hft_pkg::HUM_W-1:0]         humidity_centi,
    output logic signed [hft_pkg::TEMP_W-1:0] temperature_centi
);
    import hft_pkg::*;

    // Classified frames travel from the byte intake to the scaler through
    // the queue, so a stalled output does not stop byte intake at once.
    logic        push_valid, push_ready;
    frame_rec_t  push_rec;
    logic        pop_valid, pop_ready;
    frame_rec_t  pop_rec;

    hft_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .frame_start(frame_start),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    hft_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_rec  (push_rec),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec)
    );

    // The scaler multiplies the raw codes, then the result register keeps
    // the last good reading and presents one transfer per check byte.
    hft_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_rec          (pop_rec),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame_status     (frame_status),
        .humidity_centi   (humidity_centi),
        .temperature_centi(temperature_centi)
    );

endmodule

@@ sv/hft_front.sv @@
// ----------------------------------------------------------------------------
// hft_front: byte intake and frame classification
// Counts reply bytes, runs the CRC, gathers the payload and pushes one
// classified frame record per check byte.
// ----------------------------------------------------------------------------
module hft_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               push_valid,
    input  logic               push_ready,
    output hft_pkg::frame_rec_t push_rec
);
    import hft_pkg::*;

    logic [IDX_W-1:0]     byte_index_reg, byte_index_next;
    logic [7:0]           crc_reg, crc_next;
    logic [7:0]           status_reg, status_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;

    logic [IDX_W-1:0]     eff_index;
    logic [7:0]           crc_base;
    logic                 is_check;
    logic                 accept;

    assign eff_index = frame_start ? '0 : byte_index_reg;
    assign crc_base  = frame_start ? CRC_INIT : crc_reg;
    assign is_check  = (eff_index >= IDX_W'(LAST_DATA));
    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign push_valid = accept && is_check;

    always_comb
    begin
        push_rec.hum_code  = payload_reg[PAYLOAD_W-1:CODE_W];
        push_rec.temp_code = payload_reg[CODE_W-1:0];
        // A CRC mismatch outranks busy, and busy outranks not calibrated.
        if (crc_reg != rx_byte)
        begin
            push_rec.status = ST_CRC;
        end
        else if (status_reg[BUSY_BIT])
        begin
            push_rec.status = ST_BUSY;
        end
        else if (!status_reg[CAL_BIT])
        begin
            push_rec.status = ST_UNCAL;
        end
        else
        begin
            push_rec.status = ST_OK;
        end
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        status_next     = status_reg;
        payload_next    = payload_reg;
        if (accept)
        begin
            if (is_check)
            begin
                byte_index_next = '0;
                crc_next        = CRC_INIT;
            end
            else
            begin
                crc_next        = crc8_byte(crc_base, rx_byte);
                byte_index_next = eff_index + IDX_W'(1);
                if (eff_index == '0)
                begin
                    status_next = rx_byte;
                end
                else
                begin
                    payload_next = {payload_reg[PAYLOAD_W-9:0], rx_byte};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            crc_reg        <= CRC_INIT;
            status_reg     <= '0;
            payload_reg    <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            status_reg     <= status_next;
            payload_reg    <= payload_next;
        end
    end

    // The counter never passes the check byte position.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= IDX_W'(LAST_DATA))
        else $error("byte counter out of range");

    // A check byte restarts the counter and the CRC.
    a_check_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |=> (byte_index_reg == '0) && (crc_reg == CRC_INIT))
        else $error("counter or CRC not restarted after check byte");

    // A start flag always takes the byte as byte 0.
    a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_start) |=> (byte_index_reg == IDX_W'(1)))
        else $error("start flag did not resynchronize the counter");

endmodule

@@ sv/hft_queue.sv @@
// ----------------------------------------------------------------------------
// hft_queue: short frame record queue
// Decouples the byte intake from the scaling pipeline.
// ----------------------------------------------------------------------------
module hft_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  hft_pkg::frame_rec_t push_rec,
    output logic               pop_valid,
    input  logic               pop_ready,
    output hft_pkg::frame_rec_t pop_rec
);
    import hft_pkg::*;

    frame_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("push did not raise the count");

endmodule

@@ sv/hft_back.sv @@
// ----------------------------------------------------------------------------
// hft_back: reading scaler and result register
// Multiplies the raw codes by the scale constants, then updates the held
// readings on a good frame and presents one result per frame.
// ----------------------------------------------------------------------------
module hft_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  hft_pkg::frame_rec_t       pop_rec,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                frame_status,
    output logic [hft_pkg::HUM_W-1:0] humidity_centi,
    output logic signed [hft_pkg::TEMP_W-1:0] temperature_centi
);
    import hft_pkg::*;

    // Product stage.
    logic                a_valid_reg, a_valid_next;
    frame_status_t       a_status_reg;
    logic [HPROD_W-1:0]  a_hprod_reg;
    logic [TPROD_W-1:0]  a_tprod_reg;

    // Result stage; the humidity and temperature registers are the held readings.
    logic                out_valid_reg, out_valid_next;
    frame_status_t       out_status_reg;
    logic [HUM_W-1:0]    out_hum_reg, out_hum_next;
    logic [TEMP_W-1:0]   out_temp_reg, out_temp_next;

    logic                out_move;
    logic                a_load;
    logic [15:0]         temp_wide;

    assign out_move  = a_valid_reg && (!out_valid_reg || out_ready);
    assign pop_ready = !a_valid_reg || out_move;
    assign a_load    = pop_valid && pop_ready;

    assign temp_wide = {1'b0, a_tprod_reg[TPROD_W-1:CODE_W]} - TEMP_OFFSET;

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        out_valid_next = out_valid_reg;
        out_hum_next   = out_hum_reg;
        out_temp_next  = out_temp_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_move)
        begin
            out_valid_next = 1'b1;
            a_valid_next   = 1'b0;
            if (a_status_reg == ST_OK)
            begin
                out_hum_next  = a_hprod_reg[HPROD_W-1:CODE_W];
                out_temp_next = temp_wide[TEMP_W-1:0];
            end
        end
        if (a_load)
        begin
            a_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_hum_reg    <= '0;
            out_temp_reg   <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            out_hum_reg   <= out_hum_next;
            out_temp_reg  <= out_temp_next;
            if (out_move)
            begin
                out_status_reg <= a_status_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_status_reg <= pop_rec.status;
            a_hprod_reg  <= HPROD_W'(pop_rec.hum_code) * HPROD_W'(HUM_SCALE);
            a_tprod_reg  <= TPROD_W'(pop_rec.temp_code) * TPROD_W'(TEMP_SCALE);
        end
    end

    assign out_valid         = out_valid_reg;
    assign frame_status      = out_status_reg;
    assign humidity_centi    = out_hum_reg;
    assign temperature_centi = $signed(out_temp_reg);

    // A failed frame leaves the held readings untouched.
    a_keep_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_move && (a_status_reg != ST_OK))
            |=> ($stable(out_hum_reg) && $stable(out_temp_reg)))
        else $error("held reading changed on a failed frame");

    // Scaled humidity stays below 100 percent.
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_hum_reg < HUM_W'(10000))
        else $error("humidity out of range");

    // The product stage never loads while its entry is stuck.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !out_move) |-> !a_load)
        else $error("product stage overwritten");

endmodule

@@ test/reply_check_pkg.sv @@
// ----------------------------------------------------------------------------
// reply_check_pkg: expected-reading scoreboard for the sensor reply decoder
// Tracks the byte position, CRC and held reading of the decoder and checks
// every output transfer against the oldest expected reading.
// ----------------------------------------------------------------------------
package reply_check_pkg;

    import hft_pkg::frame_status_t;
    import hft_pkg::ST_OK;
    import hft_pkg::ST_CRC;
    import hft_pkg::ST_BUSY;
    import hft_pkg::ST_UNCAL;

    class reply_scoreboard;

        localparam logic [7:0] SEED       = 8'hFF;
        localparam logic [7:0] POLY       = 8'h31;
        localparam logic [2:0] CHECK_POS  = 3'd6;
        localparam int unsigned HUM_FULL  = 10000;
        localparam int unsigned TEMP_SPAN = 20000;
        localparam logic [14:0] TEMP_OFF  = 15'd5000;
        localparam int unsigned MAX_PRINT = 100;

        typedef struct {
            frame_status_t      status;
            logic [13:0]        hum;
            logic signed [14:0] temp;
        } reading_t;

        reading_t           expected_readings[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        status_count[4];

        logic [2:0]         pos;
        logic [7:0]         crc;
        logic [7:0]         stat;
        logic [39:0]        codes;
        logic [13:0]        last_hum;
        logic signed [14:0] last_temp;

        function new();
            pos       = '0;
            crc       = SEED;
            stat      = '0;
            codes     = '0;
            last_hum  = '0;
            last_temp = '0;
            errors    = 0;
            checked   = 0;
            foreach (status_count[i])
            begin
                status_count[i] = 0;
            end
        endfunction

        // Bitwise CRC-8, most significant bit first.
        function logic [7:0] crc_next(logic [7:0] acc, logic [7:0] data);
            logic [7:0] r;
            r = acc ^ data;
            repeat (8)
            begin
                r = r[7] ? ((r << 1) ^ POLY) : (r << 1);
            end
            return r;
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        // Advances the decoder state by one accepted byte and queues the
        // reading that a check byte produces.
        function void note_byte(logic [7:0] b, logic start);
            reading_t      r;
            frame_status_t st;
            logic [63:0]   hp;
            logic [63:0]   tp;
            if (start)
            begin
                pos = '0;
                crc = SEED;
            end
            if (pos < CHECK_POS)
            begin
                crc = crc_next(crc, b);
                if (pos == 0)
                begin
                    stat = b;
                end
                else
                begin
                    codes = {codes[31:0], b};
                end
                pos = pos + 3'd1;
                return;
            end
            // A CRC fault hides busy, and busy hides a missing calibration.
            if (crc != b)
            begin
                st = ST_CRC;
            end
            else if (stat[hft_pkg::BUSY_BIT])
            begin
                st = ST_BUSY;
            end
            else if (!stat[hft_pkg::CAL_BIT])
            begin
                st = ST_UNCAL;
            end
            else
            begin
                st = ST_OK;
            end
            if (st == ST_OK)
            begin
                hp        = 64'(codes[39:20]) * 64'(HUM_FULL);
                tp        = 64'(codes[19:0]) * 64'(TEMP_SPAN);
                last_hum  = hp[33:20];
                last_temp = tp[34:20] - TEMP_OFF;
            end
            pos      = '0;
            crc      = SEED;
            r.status = st;
            r.hum    = last_hum;
            r.temp   = last_temp;
            expected_readings.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINT)
            begin
                $display("mismatch %0d: %s", errors, msg);
            end
        endtask

        task check_reading(logic [1:0] status, logic [13:0] hum, logic signed [14:0] temp);
            reading_t r;
            checked++;
            status_count[status]++;
            if (expected_readings.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no reading expected",
                                          checked));
                return;
            end
            r = expected_readings.pop_front();
            if (status != r.status)
            begin
                report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                          checked, status, r.status));
            end
            if (hum != r.hum)
            begin
                report_mismatch($sformatf("result %0d humidity %0d, expected %0d",
                                          checked, hum, r.hum));
            end
            if (temp != r.temp)
            begin
                report_mismatch($sformatf("result %0d temperature %0d, expected %0d",
                                          checked, temp, r.temp));
            end
        endtask

    endclass

endpackage

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the humidity/temperature reply decoder
// Feeds directed and random seven-byte replies, broken replies and noise,
// and checks status and held readings of every output transfer.
// ----------------------------------------------------------------------------
module tb_top;

    import hft_pkg::*;
    import reply_check_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned HOLD_AFTER   = 60;
    localparam int unsigned DRAIN_AT     = 900;
    localparam int unsigned TAIL_CYCLES  = 8;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               frame_start;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         frame_status;
    logic [HUM_W-1:0]   humidity_centi;
    logic signed [TEMP_W-1:0] temperature_centi;

    reply_scoreboard    sb;
    int unsigned        bytes_sent;
    int unsigned        backpressure_cycles;
    bit                 send_burst;
    bit                 take_burst;
    bit                 hold_done;
    bit                 drain_done;
    bit                 last_was_frame;

    humidity_temp_frame_decoder dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .frame_start       (frame_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .frame_status      (frame_status),
        .humidity_centi    (humidity_centi),
        .temperature_centi (temperature_centi)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // One byte transfer. Inputs move on the falling edge; in_ready is
    // sampled on the rising edge, so the transfer is seen exactly where the
    // decoder sees it. Idle gaps are skipped during burst stretches.
    task send_byte(input logic [7:0] b, input logic s);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
        begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk) in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= s;
        @(posedge clk);
        while (!in_ready)
        begin
            backpressure_cycles++;
            @(posedge clk);
        end
        sb.note_byte(b, s);
        bytes_sent++;
    endtask

    // A complete reply. The check byte is made wrong on request by flipping
    // at least one of its bits.
    task send_frame(input logic [7:0] stat, input logic [19:0] hum_code,
                    input logic [19:0] temp_code, input bit lead_start, input bit corrupt);
        logic [7:0] bytes[7];
        logic [7:0] acc;
        acc      = 8'hFF;
        bytes[0] = stat;
        bytes[1] = hum_code[19:12];
        bytes[2] = hum_code[11:4];
        bytes[3] = {hum_code[3:0], temp_code[19:16]};
        bytes[4] = temp_code[15:8];
        bytes[5] = temp_code[7:0];
        for (int i = 0; i < 6; i++)
        begin
            acc = sb.crc_next(acc, bytes[i]);
        end
        bytes[6] = corrupt ? (acc ^ 8'($urandom_range(1, 255))) : acc;
        for (int i = 0; i < 7; i++)
        begin
            send_byte(bytes[i], (i == 0) ? lead_start : 1'b0);
        end
    endtask

    // Random status byte: mostly a ready, calibrated sensor, with the other
    // bits left random so every status bit toggles.
    function automatic logic [7:0] pick_status();
        logic [7:0]  s;
        int unsigned p;
        s = 8'($urandom);
        p = $urandom_range(0, 99);
        if (p < 70)
        begin
            s[BUSY_BIT] = 1'b0;
            s[CAL_BIT]  = 1'b1;
        end
        else if (p < 85)
        begin
            s[BUSY_BIT] = 1'b1;
        end
        else
        begin
            s[BUSY_BIT] = 1'b0;
            s[CAL_BIT]  = 1'b0;
        end
        return s;
    endfunction

    // Codes hit both ends of the 20-bit range now and then.
    function automatic logic [19:0] pick_code();
        int unsigned p;
        p = $urandom_range(0, 19);
        if (p == 0)
        begin
            return 20'h00000;
        end
        else if (p == 1)
        begin
            return 20'hFFFFF;
        end
        return 20'($urandom);
    endfunction

    task wait_drained();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: draws a stall before every result outside take bursts, and once holds out_ready
    // low for a long stretch so the frame queue fills and in_ready drops.
    initial
    begin
        int unsigned gap;
        out_ready  = 1'b0;
        take_burst = 1'b0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                take_burst = !take_burst;
            end
            gap = take_burst ? 0 : $urandom_range(0, 3);
            if (!hold_done && sb.checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                gap       = HOLD_CYCLES;
            end
            repeat (gap)
            begin
                @(negedge clk) out_ready <= 1'b0;
            end
            @(negedge clk) out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            sb.check_reading(frame_status, humidity_centi, temperature_centi);
        end
    end

    // Stimulus: directed replies first, then a mix that is mostly complete
    // replies with random content, plus truncated replies and raw noise.
    initial
    begin
        int unsigned pick;
        int unsigned cut;
        rst_n               = 1'b0;
        in_valid            = 1'b0;
        rx_byte             = '0;
        frame_start         = 1'b0;
        bytes_sent          = 0;
        backpressure_cycles = 0;
        send_burst          = 1'b0;
        drain_done          = 1'b0;
        sb                  = new();
        repeat (10)
        begin
            @(posedge clk);
        end
        @(negedge clk) rst_n <= 1'b1;

        // Good reply with both codes at full scale.
        send_frame(8'h1C, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0);
        // Follows a finished reply without a start flag; uncalibrated.
        send_frame(8'h77, 20'h00000, 20'hFFFFF, 1'b0, 1'b0);
        // A lone byte, then a start in the middle drops it. The reply is
        // busy and uncalibrated and has a bad check byte: the CRC wins.
        send_byte(8'hFF, 1'b1);
        send_frame(8'h80, 20'h00000, 20'h00000, 1'b1, 1'b1);
        // Busy with a good CRC; held reading must stay at full scale.
        send_frame(8'h88, 20'h00000, 20'h00000, 1'b1, 1'b0);
        last_was_frame = 1'b1;

        while (bytes_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_frame(pick_status(), pick_code(), pick_code(),
                           last_was_frame ? ($urandom_range(0, 5) != 0) : 1'b1,
                           $urandom_range(0, 9) == 0);
                last_was_frame = 1'b1;
            end
            else if (pick < 88)
            begin
                // Truncated reply; the next start flag throws it away.
                cut = $urandom_range(1, 6);
                for (int i = 0; i < cut; i++)
                begin
                    send_byte(8'($urandom), i == 0);
                end
                last_was_frame = 1'b0;
            end
            else
            begin
                cut = $urandom_range(1, 10);
                for (int i = 0; i < cut; i++)
                begin
                    send_byte(8'($urandom), $urandom_range(0, 9) == 0);
                end
                last_was_frame = 1'b0;
            end
            if (!drain_done && bytes_sent >= DRAIN_AT)
            begin
                // Stop offering bytes while the outstanding results drain.
                drain_done = 1'b1;
                @(negedge clk) in_valid <= 1'b0;
                wait_drained();
            end
        end

        @(negedge clk) in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end

        $display("Sent %0d bytes, checked %0d results (ok %0d, crc %0d, busy %0d, uncal %0d).",
                 bytes_sent, sb.checked, sb.status_count[ST_OK], sb.status_count[ST_CRC],
                 sb.status_count[ST_BUSY], sb.status_count[ST_UNCAL]);
        $display("Input stalled for %0d cycles behind a %0d-cycle output hold; %0d mismatches.",
                 backpressure_cycles, HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
        begin
            $display("[humidity_temp_frame_decoder] OK");
        end
        else
        begin
            $display("[humidity_temp_frame_decoder] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("Timed out with %0d results still expected.", sb.pending());
        $display("[humidity_temp_frame_decoder] ERROR");
        $finish;
    end

endmodule
